// ===== src/dll_pkg.sv =====
// Package: request codes, defaults and shared types of the linked list engine.
`default_nettype none
package dll_pkg;
  localparam int PoolNodesDefault = 16;
  localparam int ValueBitsDefault = 32;
  localparam int ReqBits = 5;
  localparam int OutValueBits = 32;
  localparam int CountOutBits = 5;

  typedef enum logic [ReqBits-1:0] {
    REQ_CLEAR      = 5'd0,
    REQ_INS_FIRST  = 5'd1,
    REQ_INS_LAST   = 5'd2,
    REQ_CUR_FIRST  = 5'd3,
    REQ_CUR_LAST   = 5'd4,
    REQ_RD_FIRST   = 5'd5,
    REQ_RD_LAST    = 5'd6,
    REQ_DEL_FIRST  = 5'd7,
    REQ_DEL_LAST   = 5'd8,
    REQ_DEL_AFTER  = 5'd9,
    REQ_DEL_BEFORE = 5'd10,
    REQ_INS_AFTER  = 5'd11,
    REQ_INS_BEFORE = 5'd12,
    REQ_RD_CUR     = 5'd13,
    REQ_WR_CUR     = 5'd14,
    REQ_NEXT       = 5'd15,
    REQ_PREV       = 5'd16
  } req_t;
endpackage
`default_nettype wire

// ===== src/dll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/dll_alloc.sv =====
// Allocation map: lowest free node search, set and free of single nodes.
`default_nettype none
module dll_alloc #(
  parameter int POOL_NODES = dll_pkg::PoolNodesDefault,
  parameter int IW = $clog2(POOL_NODES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear_all,
  input  wire logic          set_en,
  input  wire logic [IW-1:0] set_idx,
  input  wire logic          free_en,
  input  wire logic [IW-1:0] free_idx,
  output logic      [IW-1:0] free_node
);
  logic [POOL_NODES-1:0] in_use;

  // Priority encode from the top so the lowest free node wins.
  always_comb begin
    free_node = IW'(POOL_NODES);
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_node = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      in_use <= '0;
    end else begin
      for (int i = 0; i < POOL_NODES; i++) begin
        if (set_en && set_idx == IW'(i)) begin
          in_use[i] <= 1'b1;
        end else if (free_en && free_idx == IW'(i)) begin
          in_use[i] <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/doubly_linked_list_engine_top.sv =====
// Top level: linked list engine with node memories and request sequencer.
// Sequence: one request is in work at a time. The node memories (registered read) are read
// at most twice before write-back. Clear, cursor moves to the ends, cursor write, no-ops and
// requests that fail or do nothing at once go straight to S_OUT; reads pass S_RD2, next/prev
// S_RD1; front/back inserts pass S_UNLK and S_WB2, front/back deletes S_RD2, S_UNLK and S_WB2,
// cursor inserts S_RD1, S_UNLK and S_WB2, neighbor deletes all four; a stall holds S_OUT.
// Reset: head, tail and cursor go null, count and allocation map clear; node memories keep.
`default_nettype none
module doubly_linked_list_engine_top #(
  parameter int POOL_NODES = dll_pkg::PoolNodesDefault,
  parameter int VALUE_BITS = dll_pkg::ValueBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [dll_pkg::ReqBits-1:0] req_type,
  input  wire logic signed [31:0]      value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [dll_pkg::OutValueBits-1:0] read_value,
  output logic                         error,
  output logic                         cursor_active,
  output logic                         list_empty,
  output logic [dll_pkg::CountOutBits-1:0] node_count
);
  localparam int IW = $clog2(POOL_NODES + 1);  // index incl. null code
  localparam int AW = $clog2(POOL_NODES);      // memory address
  localparam int CW = $clog2(POOL_NODES + 1);  // count
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD1   = 6'b000010,  // cursor link read in flight
    S_RD2   = 6'b000100,  // target value or link read in flight
    S_UNLK  = 6'b001000,  // fresh node write or unlink write-back
    S_WB2   = 6'b010000,  // neighbor link write-back
    S_OUT   = 6'b100000   // result waits in the output register
  } state_t;

  state_t state;
  dll_pkg::req_t req;
  logic [VALUE_BITS-1:0] val;
  logic [IW-1:0] head, tail, cursor;
  logic [CW-1:0] count;
  // node being linked or unlinked and its neighbors
  logic [IW-1:0] tgt, nb_p, nb_n;
  logic [IW-1:0] fresh;

  // Memories: value, next link, previous link.
  logic              v_we, n_we, p_we;
  logic [AW-1:0]     v_wa, n_wa, p_wa, v_ra, l_ra;
  logic [VALUE_BITS-1:0] v_wd, v_rd;
  logic [IW-1:0]     n_wd, p_wd, n_rd, p_rd;

  dll_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  dll_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(l_ra), .rdata(n_rd));
  dll_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(l_ra), .rdata(p_rd));

  logic          al_clear, al_set, al_free;
  logic [IW-1:0] al_set_idx, al_free_idx, free_node;

  dll_alloc #(.POOL_NODES(POOL_NODES), .IW(IW)) u_alloc (
    .clk(clk), .rst(rst), .clear_all(al_clear),
    .set_en(al_set), .set_idx(al_set_idx),
    .free_en(al_free), .free_idx(al_free_idx), .free_node(free_node));

  function automatic logic is_node(input logic [IW-1:0] i);
    return i < IW'(POOL_NODES);
  endfunction

  // Links read back from memory; out-of-range codes mean null.
  logic [IW-1:0] rd_next, rd_prev;
  assign rd_next = is_node(n_rd) ? n_rd : NIL;
  assign rd_prev = is_node(p_rd) ? p_rd : NIL;

  assign in_stall = (state != S_IDLE);

  logic [VALUE_BITS-1:0] res_val;
  logic                  res_err;
  logic                  accept;
  assign accept = in_valid && !in_stall;

  // Result is taken from the result registers and the list state.
  assign out_valid     = (state == S_OUT);
  assign read_value    = 32'(res_val);
  assign error         = res_err;
  assign cursor_active = is_node(cursor);
  assign list_empty    = (count == '0);
  assign node_count    = 5'(count);

  // Combinational memory and allocation controls.
  state_t        state_next;
  logic [IW-1:0] head_next, tail_next, cursor_next, tgt_next, nbp_next, nbn_next;
  logic [IW-1:0] fresh_next;
  logic [CW-1:0] count_next;
  logic [VALUE_BITS-1:0] resv_next;
  logic          rese_next;

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    cursor_next = cursor;
    count_next  = count;
    tgt_next    = tgt;
    nbp_next    = nb_p;
    nbn_next    = nb_n;
    fresh_next  = fresh;
    resv_next   = res_val;
    rese_next   = res_err;
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    v_wa = '0;   n_wa = '0;   p_wa = '0;
    v_wd = val;  n_wd = NIL;  p_wd = NIL;
    v_ra = '0;   l_ra = '0;
    al_clear = 1'b0; al_set = 1'b0; al_free = 1'b0;
    al_set_idx = NIL; al_free_idx = NIL;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          resv_next  = '0;
          rese_next  = 1'b0;
          fresh_next = free_node;
          state_next = S_OUT;
          case (req_type)
            dll_pkg::REQ_CLEAR: begin
              al_clear = 1'b1;
              head_next = NIL; tail_next = NIL; cursor_next = NIL;
              count_next = '0;
            end
            dll_pkg::REQ_CUR_FIRST: cursor_next = head;
            dll_pkg::REQ_CUR_LAST:  cursor_next = tail;
            dll_pkg::REQ_WR_CUR: begin
              if (is_node(cursor)) begin
                v_we = 1'b1; v_wa = AW'(cursor);
                v_wd = VALUE_BITS'(value);
              end
            end
            dll_pkg::REQ_INS_FIRST, dll_pkg::REQ_INS_LAST: begin
              rese_next = !is_node(free_node);
              state_next = is_node(free_node) ? S_UNLK : S_OUT;
            end
            dll_pkg::REQ_INS_AFTER, dll_pkg::REQ_INS_BEFORE: begin
              if (is_node(cursor)) begin
                rese_next = !is_node(free_node);
                if (is_node(free_node)) begin
                  l_ra = AW'(cursor);
                  state_next = S_RD1;
                end
              end
            end
            dll_pkg::REQ_RD_FIRST, dll_pkg::REQ_RD_LAST, dll_pkg::REQ_RD_CUR: begin
              tgt_next = (req_type == dll_pkg::REQ_RD_FIRST) ? head :
                         (req_type == dll_pkg::REQ_RD_LAST) ? tail : cursor;
              if (is_node(tgt_next)) begin
                v_ra = AW'(tgt_next);
                state_next = S_RD2;
              end else begin
                rese_next = 1'b1;
              end
            end
            dll_pkg::REQ_DEL_FIRST, dll_pkg::REQ_DEL_LAST: begin
              tgt_next = (req_type == dll_pkg::REQ_DEL_FIRST) ? head : tail;
              if (is_node(tgt_next)) begin
                l_ra = AW'(tgt_next);
                state_next = S_RD2;
              end
            end
            dll_pkg::REQ_DEL_AFTER, dll_pkg::REQ_DEL_BEFORE,
            dll_pkg::REQ_NEXT, dll_pkg::REQ_PREV: begin
              if (is_node(cursor)) begin
                l_ra = AW'(cursor);
                state_next = S_RD1;
              end
            end
            default: ;
          endcase
        end
      end

      // Cursor links are on the read port.
      S_RD1: begin
        state_next = S_OUT;
        case (req)
          dll_pkg::REQ_NEXT: cursor_next = rd_next;
          dll_pkg::REQ_PREV: cursor_next = rd_prev;
          dll_pkg::REQ_INS_AFTER: begin
            nbp_next = cursor; nbn_next = rd_next;
            state_next = S_UNLK;
          end
          dll_pkg::REQ_INS_BEFORE: begin
            nbp_next = rd_prev; nbn_next = cursor;
            state_next = S_UNLK;
          end
          default: begin
            // delete after / before: fetch the neighbor's links
            tgt_next = (req == dll_pkg::REQ_DEL_AFTER) ? rd_next : rd_prev;
            if (is_node(tgt_next)) begin
              l_ra = AW'(tgt_next);
              state_next = S_RD2;
            end
          end
        endcase
      end

      // Target's value or links are on the read port.
      S_RD2: begin
        state_next = S_OUT;
        if (req == dll_pkg::REQ_RD_FIRST || req == dll_pkg::REQ_RD_LAST ||
            req == dll_pkg::REQ_RD_CUR) begin
          resv_next = v_rd;
        end else begin
          nbp_next = rd_prev;
          nbn_next = rd_next;
          state_next = S_UNLK;
        end
      end

      // Write the fresh node, or unlink the target with the first neighbor fix.
      S_UNLK: begin
        state_next = S_WB2;
        if (req == dll_pkg::REQ_INS_FIRST || req == dll_pkg::REQ_INS_LAST ||
            req == dll_pkg::REQ_INS_AFTER || req == dll_pkg::REQ_INS_BEFORE) begin
          if (req == dll_pkg::REQ_INS_FIRST) begin
            nbp_next = NIL; nbn_next = head;
          end else if (req == dll_pkg::REQ_INS_LAST) begin
            nbp_next = tail; nbn_next = NIL;
          end
          al_set = 1'b1; al_set_idx = fresh;
          v_we = 1'b1; v_wa = AW'(fresh); v_wd = val;
          n_we = 1'b1; n_wa = AW'(fresh); n_wd = nbn_next;
          p_we = 1'b1; p_wa = AW'(fresh); p_wd = nbp_next;
          count_next = count + CW'(1);
          if (!is_node(nbp_next)) begin
            head_next = fresh;
          end
          if (!is_node(nbn_next)) begin
            tail_next = fresh;
          end
          tgt_next = fresh;
        end else begin
          al_free = 1'b1; al_free_idx = tgt;
          if (count != '0) begin
            count_next = count - CW'(1);
          end
          if (cursor == tgt) begin
            cursor_next = NIL;
          end
          if (is_node(nb_p)) begin
            n_we = 1'b1; n_wa = AW'(nb_p); n_wd = nb_n;
          end else begin
            head_next = nb_n;
          end
          if (!is_node(nb_n)) begin
            tail_next = nb_p;
          end
        end
      end

      // Neighbor fixes: both neighbors' links on insert, prev link of the node after on delete.
      S_WB2: begin
        state_next = S_OUT;
        if (req == dll_pkg::REQ_INS_FIRST || req == dll_pkg::REQ_INS_LAST ||
            req == dll_pkg::REQ_INS_AFTER || req == dll_pkg::REQ_INS_BEFORE) begin
          if (is_node(nb_p)) begin
            n_we = 1'b1; n_wa = AW'(nb_p); n_wd = tgt;
          end
          if (is_node(nb_n)) begin
            p_we = 1'b1; p_wa = AW'(nb_n); p_wd = tgt;
          end
        end else if (is_node(nb_n)) begin
          p_we = 1'b1; p_wa = AW'(nb_n); p_wd = nb_p;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= NIL;
      tail   <= NIL;
      cursor <= NIL;
      count  <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      cursor <= is_node(cursor_next) ? cursor_next : NIL;
      count  <= count_next;
    end
  end

  // Payload registers: capture the request and hold working indexes.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= dll_pkg::req_t'(req_type);
      val <= VALUE_BITS'(value);
    end
    tgt     <= tgt_next;
    nb_p    <= nbp_next;
    nb_n    <= nbn_next;
    fresh   <= fresh_next;
    res_val <= resv_next;
    res_err <= rese_next;
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the linked list engine: directed and randomized requests checked against a list predictor.
`timescale 1ns / 1ps
module tb_top;
  localparam int Nodes = 16;
  localparam int Nil = Nodes;
  localparam int IdleLimit = 2000;

  typedef struct packed {
    logic [4:0]         req;
    logic signed [31:0] val;
  } request_t;

  typedef struct packed {
    logic signed [31:0] rd;
    logic               err;
    logic               cur_act;
    logic               empty;
    logic [4:0]         cnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] req_type = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic error;
  logic cursor_active;
  logic list_empty;
  logic [4:0] node_count;

  doubly_linked_list_engine_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .error(error), .cursor_active(cursor_active),
    .list_empty(list_empty), .node_count(node_count)
  );

  always #10 clk = ~clk;

  // Predictor copy of the list state; null is coded as Nil.
  logic signed [31:0] pool_val [Nodes];
  int pool_next [Nodes];
  int pool_prev [Nodes];
  bit pool_used [Nodes];
  int head_node = Nil, tail_node = Nil, cur_node = Nil, list_len = 0;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  bit failed = 1'b0;
  bit stim_done = 1'b0;

  function automatic int free_node();
    for (int i = 0; i < Nodes; i++) if (!pool_used[i]) return i;
    return Nil;
  endfunction

  function automatic void link_in(int x, int p, int n, logic signed [31:0] v);
    pool_used[x] = 1'b1;
    pool_val[x] = v;
    pool_prev[x] = p;
    pool_next[x] = n;
    if (p != Nil) pool_next[p] = x; else head_node = x;
    if (n != Nil) pool_prev[n] = x; else tail_node = x;
    list_len++;
  endfunction

  function automatic void unlink(int x);
    int p, n;
    if (x == Nil) return;
    p = pool_prev[x];
    n = pool_next[x];
    if (p != Nil) pool_next[p] = n; else head_node = n;
    if (n != Nil) pool_prev[n] = p; else tail_node = p;
    if (cur_node == x) cur_node = Nil;
    pool_used[x] = 1'b0;
    if (list_len > 0) list_len--;
  endfunction

  // Apply one request to the predictor and return its expected outcome.
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int x;
    o = '0;
    case (r.req)
      dll_pkg::REQ_CLEAR: begin
        for (int i = 0; i < Nodes; i++) pool_used[i] = 1'b0;
        head_node = Nil; tail_node = Nil; cur_node = Nil; list_len = 0;
      end
      dll_pkg::REQ_INS_FIRST, dll_pkg::REQ_INS_LAST: begin
        x = free_node();
        if (x == Nil) o.err = 1'b1;
        else if (r.req == dll_pkg::REQ_INS_FIRST) link_in(x, Nil, head_node, r.val);
        else link_in(x, tail_node, Nil, r.val);
      end
      dll_pkg::REQ_CUR_FIRST: cur_node = head_node;
      dll_pkg::REQ_CUR_LAST: cur_node = tail_node;
      dll_pkg::REQ_RD_FIRST:
        if (head_node != Nil) o.rd = pool_val[head_node]; else o.err = 1'b1;
      dll_pkg::REQ_RD_LAST:
        if (tail_node != Nil) o.rd = pool_val[tail_node]; else o.err = 1'b1;
      dll_pkg::REQ_DEL_FIRST: unlink(head_node);
      dll_pkg::REQ_DEL_LAST: unlink(tail_node);
      dll_pkg::REQ_DEL_AFTER: if (cur_node != Nil) unlink(pool_next[cur_node]);
      dll_pkg::REQ_DEL_BEFORE: if (cur_node != Nil) unlink(pool_prev[cur_node]);
      dll_pkg::REQ_INS_AFTER, dll_pkg::REQ_INS_BEFORE: if (cur_node != Nil) begin
        x = free_node();
        if (x == Nil) o.err = 1'b1;
        else if (r.req == dll_pkg::REQ_INS_AFTER)
          link_in(x, cur_node, pool_next[cur_node], r.val);
        else link_in(x, pool_prev[cur_node], cur_node, r.val);
      end
      dll_pkg::REQ_RD_CUR:
        if (cur_node != Nil) o.rd = pool_val[cur_node]; else o.err = 1'b1;
      dll_pkg::REQ_WR_CUR: if (cur_node != Nil) pool_val[cur_node] = r.val;
      dll_pkg::REQ_NEXT: if (cur_node != Nil) cur_node = pool_next[cur_node];
      dll_pkg::REQ_PREV: if (cur_node != Nil) cur_node = pool_prev[cur_node];
      default: ;
    endcase
    o.cur_act = (cur_node != Nil);
    o.empty = (list_len == 0);
    o.cnt = list_len[4:0];
    return o;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -1;
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  // Weighted mix: clear, invalid codes, cursor inserts, front/back inserts, then any request.
  function automatic logic [4:0] rand_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) return dll_pkg::REQ_CLEAR;
    if (k < 4) return 5'($urandom_range(17, 31));
    if (k < 30)
      return 5'($urandom_range(0, 1) ? dll_pkg::REQ_INS_AFTER : dll_pkg::REQ_INS_BEFORE);
    if (k < 42) return 5'($urandom_range(dll_pkg::REQ_INS_FIRST, dll_pkg::REQ_INS_LAST));
    return 5'($urandom_range(dll_pkg::REQ_INS_FIRST, dll_pkg::REQ_PREV));
  endfunction

  initial begin
    request_t r;
    logic [4:0] directed [] = '{dll_pkg::REQ_RD_FIRST, dll_pkg::REQ_RD_LAST,
      dll_pkg::REQ_RD_CUR, dll_pkg::REQ_DEL_FIRST, dll_pkg::REQ_DEL_LAST,
      dll_pkg::REQ_INS_AFTER, dll_pkg::REQ_WR_CUR, dll_pkg::REQ_NEXT, dll_pkg::REQ_PREV,
      dll_pkg::REQ_INS_FIRST, dll_pkg::REQ_DEL_FIRST, dll_pkg::REQ_INS_LAST,
      dll_pkg::REQ_CUR_FIRST, dll_pkg::REQ_INS_BEFORE, dll_pkg::REQ_INS_AFTER,
      dll_pkg::REQ_DEL_BEFORE, dll_pkg::REQ_DEL_AFTER, dll_pkg::REQ_WR_CUR,
      dll_pkg::REQ_RD_CUR, dll_pkg::REQ_NEXT, dll_pkg::REQ_CUR_LAST, dll_pkg::REQ_PREV,
      dll_pkg::REQ_RD_LAST, 5'd31, dll_pkg::REQ_CLEAR};
    // Directed: empty-list reads, sole-node delete, cursor edges, then fill the pool.
    foreach (directed[i]) begin
      r.req = directed[i];
      r.val = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      pending_reqs.push_back(r);
    end
    for (int i = 0; i < 17; i++) begin
      r.req = dll_pkg::REQ_INS_LAST;
      r.val = rand_value();
      pending_reqs.push_back(r);
    end
    for (int i = 0; i < 1260; i++) begin
      r.req = rand_req();
      r.val = rand_value();
      pending_reqs.push_back(r);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: hold each transaction until accepted, then idle a random gap.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(apply_request(request_t'{req_type, value}));
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (drv_gap > 0) begin
        in_valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        req_type <= pending_reqs[0].req;
        value <= pending_reqs.pop_front().val;
        drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result transaction");
          failed <= 1'b1;
        end else begin
          e = expected_outcomes.pop_front();
          if (read_value !== e.rd) begin
            $error("read_value expected %0d actual %0d", e.rd, read_value); failed <= 1'b1;
          end
          if (error !== e.err) begin
            $error("error expected %0d actual %0d", e.err, error); failed <= 1'b1;
          end
          if (cursor_active !== e.cur_act) begin
            $error("cursor_active expected %0d actual %0d", e.cur_act, cursor_active);
            failed <= 1'b1;
          end
          if (list_empty !== e.empty) begin
            $error("list_empty expected %0d actual %0d", e.empty, list_empty); failed <= 1'b1;
          end
          if (node_count !== e.cnt) begin
            $error("node_count expected %0d actual %0d", e.cnt, node_count); failed <= 1'b1;
          end
        end
      end
      // Draw a stall length per result; drop stall once it runs out.
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall)
          stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // Watchdog and end of run.
  int idle_cycles = 0;
  int drain = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top failed");
        $finish;
      end else if (stim_done && !in_valid && expected_outcomes.size() == 0) begin
        drain <= drain + 1;
        if (drain >= 20) begin
          if (!failed) $display("tb_top passed");
          else $display("tb_top failed");
          $finish;
        end
      end
    end
  end
endmodule
